// ===== hdl/fpars_pkg.sv =====
`default_nettype none

package fpars_pkg;

  // Field widths fixed by the item formats.
  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  // Default tree depth handed to the top level.
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Reset value of the positions_in_use register.
  localparam logic [POS_W-1:0] LIMIT_RESET = 10'd1023;

  // Command codes.
  localparam logic MODE_ASSIGN = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        left_bound;
    logic [POS_W-1:0]        right_bound;
  } cmd_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    bad_range;
  } res_item_t;

endpackage

`default_nettype wire

// ===== hdl/fpars_addsub.sv =====
`default_nettype none

// Shared 64-bit adder/subtractor: y = a + b, or a - b when sub is set.
module fpars_addsub
  import fpars_pkg::*;
(
  input  wire logic [SUM_W-1:0] a,
  input  wire logic [SUM_W-1:0] b,
  input  wire logic             sub,
  output logic      [SUM_W-1:0] y
);

  logic [SUM_W-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign y     = a + b_eff + {{(SUM_W-1){1'b0}}, sub};

endmodule

`default_nettype wire

// ===== hdl/fenwick_point_assign_range_sum_top.sv =====
`default_nettype none

// Fenwick (binary indexed) tree with point assignment and range sums.
// Items arrive on the cmd channel (cmd_valid / cmd_stall / cmd). An item with
// mode MODE_ASSIGN replaces the value at one position and returns nothing; an
// item with mode MODE_QUERY returns one item on the res channel holding the
// wrapped 64-bit sum over left_bound..right_bound, or a zero sum with
// bad_range set when the bounds are not valid. Position zero and positions
// above positions_in_use (written through cfg_we / cfg_data) are ignored.
// One item is worked on at a time and cmd_stall is high meanwhile. An assign
// reads the old value, stores the new one, forms the difference and then reads
// and writes one tree node per step of its upward lowbit chain (at most
// log2(TABLE_DEPTH), 10 nodes at the default depth), in that order through the
// single tree memory port and the one shared adder. A query makes one tree read
// per node of each downward chain and then holds its result until the output
// register is free; a query with bad bounds goes straight to the result.
// After reset the block clears all TABLE_DEPTH entries of both memories, one
// entry per cycle, while cmd_stall stays high; configuration writes are
// taken during that pass. A result waits in the output register while
// res_stall is high; the block keeps accepting and working on items and only
// holds a finished query until the register frees up.
module fenwick_point_assign_range_sum_top
  import fpars_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_stall,
  input  wire cmd_item_t        cmd,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_item_t             res,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_data
);

  // Address width of the memories and width of the walking index. The walk
  // index has one spare bit so that an upward step past the last node is
  // still visible.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [WW-1:0] MAX_POS = WW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_OLD  = 4'd2;
  localparam logic [3:0] S_A_DIFF = 4'd3;
  localparam logic [3:0] S_A_RD   = 4'd4;
  localparam logic [3:0] S_A_WR   = 4'd5;
  localparam logic [3:0] S_Q_HI   = 4'd6;
  localparam logic [3:0] S_Q_LO   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [WW-1:0]    walk;
  logic [WW-1:0]    walk_next;
  logic [WW-1:0]    lo_walk;
  logic             pend;
  logic             bad;
  logic [SUM_W-1:0] acc;
  logic [VAL_W-1:0] nv;
  logic [POS_W-1:0] positions_in_use;

  // Memories.
  logic [VAL_W-1:0] stored_values [TABLE_DEPTH];
  logic [SUM_W-1:0] tree_sums     [TABLE_DEPTH];
  logic [VAL_W-1:0] sv_rdata;
  logic [SUM_W-1:0] tree_rdata;
  logic             sv_we;
  logic [VAL_W-1:0] sv_wdata;
  logic             tree_we;
  logic [SUM_W-1:0] tree_wdata;
  logic [AW-1:0]    mem_addr;

  // Shared adder operands.
  logic [SUM_W-1:0] alu_a;
  logic [SUM_W-1:0] alu_b;
  logic             alu_sub;
  logic [SUM_W-1:0] alu_y;

  logic [WW-1:0] lim;
  logic [WW-1:0] cfg_w;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] lo_w;
  logic [WW-1:0] hi_w;
  logic [WW-1:0] walk_up;
  logic [WW-1:0] walk_down;
  logic          cmd_take;
  logic          a_ok;
  logic          q_bad;
  logic          res_free;

  // Effective limit is the register capped at the last tree node.
  assign cfg_w = WW'(positions_in_use);
  assign lim   = (cfg_w > MAX_POS) ? MAX_POS : cfg_w;
  assign pos_w = WW'(cmd.position);
  assign lo_w  = WW'(cmd.left_bound);
  assign hi_w  = WW'(cmd.right_bound);

  assign a_ok  = (pos_w != '0) && (pos_w <= lim);
  assign q_bad = (lo_w == '0) || (lo_w > lim) || (hi_w > lim);

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign res_free  = !res_valid || !res_stall;

  // Upward step adds the lowest set bit; downward step clears it.
  assign walk_up   = walk + (walk & (~walk + WW'(1)));
  assign walk_down = walk & (walk - WW'(1));

  assign mem_addr = walk[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      positions_in_use <= LIMIT_RESET;
    end else if (cfg_we) begin
      positions_in_use <= cfg_data;
    end
  end

  // Both memories are addressed by the walk index and read every cycle.
  always_ff @(posedge clk) begin
    if (sv_we) begin
      stored_values[mem_addr] <= sv_wdata;
    end
    sv_rdata <= stored_values[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_sums[mem_addr] <= tree_wdata;
    end
    tree_rdata <= tree_sums[mem_addr];
  end

  assign sv_we      = (state == S_CLEAR) || (state == S_A_DIFF);
  assign sv_wdata   = (state == S_CLEAR) ? '0 : nv;
  assign tree_we    = (state == S_CLEAR) || (state == S_A_WR);
  assign tree_wdata = (state == S_CLEAR) ? '0 : alu_y;

  // Operand selection for the shared adder. In the tree update states (S_A_RD,
  // S_A_WR) acc holds the difference between the new and the old value.
  always_comb begin
    alu_a   = acc;
    alu_b   = tree_rdata;
    alu_sub = 1'b0;
    unique case (state)
      S_A_DIFF: begin
        alu_a   = {{(SUM_W-VAL_W){nv[VAL_W-1]}}, nv};
        alu_b   = {{(SUM_W-VAL_W){sv_rdata[VAL_W-1]}}, sv_rdata};
        alu_sub = 1'b1;
      end
      S_A_WR: begin
        alu_a = tree_rdata;
        alu_b = acc;
      end
      S_Q_LO: begin
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  fpars_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  // Sequencer. A query sums the right-bound chain into acc and then
  // subtracts the chain of left_bound-1, one tree read per cycle, with pend
  // marking that the read data of the previous cycle is still to be used.
  always_comb begin
    state_next = state;
    walk_next  = walk;
    unique case (state)
      S_CLEAR: begin
        walk_next = walk + WW'(1);
        if (walk == MAX_POS) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_take) begin
          if (cmd.mode == MODE_QUERY) begin
            walk_next  = hi_w;
            state_next = q_bad ? S_DONE : S_Q_HI;
          end else if (a_ok) begin
            walk_next  = pos_w;
            state_next = S_A_OLD;
          end
        end
      end
      S_A_OLD:  state_next = S_A_DIFF;
      S_A_DIFF: state_next = S_A_RD;
      S_A_RD:   state_next = S_A_WR;
      S_A_WR: begin
        walk_next  = walk_up;
        state_next = (walk_up > MAX_POS) ? S_IDLE : S_A_RD;
      end
      S_Q_HI: begin
        if (walk != '0) begin
          walk_next = walk_down;
        end else if (!pend) begin
          walk_next  = lo_walk;
          state_next = S_Q_LO;
        end
      end
      S_Q_LO: begin
        if (walk != '0) begin
          walk_next = walk_down;
        end else if (!pend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      walk      <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      walk  <= walk_next;
      if ((state == S_Q_HI) || (state == S_Q_LO)) begin
        pend <= (walk != '0);
      end else begin
        pend <= 1'b0;
      end
      if ((state == S_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      nv      <= cmd.new_value;
      lo_walk <= lo_w - WW'(1);
      bad     <= q_bad;
      acc     <= '0;
    end else if (state == S_A_DIFF) begin
      acc <= alu_y;
    end else if (((state == S_Q_HI) || (state == S_Q_LO)) && pend) begin
      acc <= alu_y;
    end
    if ((state == S_DONE) && res_free) begin
      res.range_sum <= acc;
      res.bad_range <= bad;
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> cmd_stall)
    else $error("cmd accepted while the sequencer is busy");

  a_bad_query_done: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && (cmd.mode == MODE_QUERY) && q_bad) |=> ((state == S_DONE) && bad))
    else $error("bad query did not go straight to the result");

  a_update_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WR) |-> ((walk != '0) && (walk <= MAX_POS)))
    else $error("tree update outside the node range");

  a_update_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WR) |=> ((state == S_A_RD) || (state == S_IDLE)))
    else $error("update walk left its loop");

  a_bad_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.bad_range) |-> (res.range_sum == '0))
    else $error("flagged result carries a nonzero sum");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/range_sum_checker.sv =====
`default_nettype none

// Watches both channels and the limit register, keeps its own binary indexed
// tree, and checks every returned range sum against the oldest query still
// waiting for an answer.
module range_sum_checker
  import fpars_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire logic             cmd_stall,
  input  wire cmd_item_t        cmd,
  input  wire logic             res_valid,
  input  wire logic             res_stall,
  input  wire res_item_t        res,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [VAL_W-1:0] held_value [TABLE_DEPTH];
  logic [SUM_W-1:0]        node_sum   [TABLE_DEPTH];
  logic [POS_W-1:0]        top_position;
  res_item_t               expected_sums [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int usable_top();
    int lim;
    lim = int'(top_position);
    if (lim > TABLE_DEPTH - 1) lim = TABLE_DEPTH - 1;
    return lim;
  endfunction

  // Replace one value and push the difference up the lowbit chain. The chain
  // always runs to the end of the table, whatever the current limit.
  function automatic void store_value(int at, logic signed [VAL_W-1:0] v);
    logic [SUM_W-1:0] delta;
    int p;
    delta = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v}
          - {{(SUM_W-VAL_W){held_value[IW'(at)][VAL_W-1]}}, held_value[IW'(at)]};
    held_value[IW'(at)] = v;
    p = at;
    while (p < TABLE_DEPTH) begin
      node_sum[IW'(p)] += delta;
      p += p & -p;
    end
  endfunction

  function automatic logic [SUM_W-1:0] prefix_total(int upto);
    logic [SUM_W-1:0] acc;
    int x;
    acc = '0;
    x = upto;
    while (x > 0 && x < TABLE_DEPTH) begin
      acc += node_sum[IW'(x)];
      x &= x - 1;
    end
    return acc;
  endfunction

  function automatic res_item_t answer_query(int lo, int hi, int lim);
    res_item_t r;
    if (lo == 0 || lo > lim || hi > lim) begin
      r.range_sum = '0;
      r.bad_range = 1'b1;
    end else begin
      r.range_sum = prefix_total(hi) - prefix_total(lo - 1);
      r.bad_range = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    int errs;
    int lim;
    errs = 0;
    if (rst) begin
      held_value   = '{default: '0};
      node_sum     = '{default: '0};
      top_position = LIMIT_RESET;
      expected_sums.delete();
    end else begin
      // Check the outgoing result first: it can only answer an earlier query.
      if (res_valid && !res_stall) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result: range_sum %0d bad_range %0b",
                 res.range_sum, res.bad_range);
          errs++;
        end else begin
          want = expected_sums.pop_front();
          if (res.range_sum !== want.range_sum) begin
            $error("range_sum mismatch: expected %0d, actual %0d",
                   want.range_sum, res.range_sum);
            errs++;
          end
          if (res.bad_range !== want.bad_range) begin
            $error("bad_range mismatch: expected %0b, actual %0b",
                   want.bad_range, res.bad_range);
            errs++;
          end
        end
      end
      // An item taken at this edge still sees the limit from before a write
      // at the same edge.
      if (cmd_valid && !cmd_stall) begin
        lim = usable_top();
        if (cmd.mode == MODE_ASSIGN) begin
          if (int'(cmd.position) != 0 && int'(cmd.position) <= lim)
            store_value(int'(cmd.position), cmd.new_value);
        end else begin
          expected_sums.push_back(answer_query(int'(cmd.left_bound),
                                               int'(cmd.right_bound), lim));
        end
      end
      if (cfg_we) top_position = cfg_data;
    end
    fail_count <= fail_count + errs;
    pending    <= expected_sums.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

// Top of the bench. It drives items into the tree, writes the limit register
// between phases, randomizes the sender gaps and the receiver stalls, and
// reports the verdict. All prediction and comparison lives in the checker.
module testbench
  import fpars_pkg::*;
();

  // Largest position that fits in the position fields.
  localparam int POS_MAX = (1 << POS_W) - 1;
  // Time allowed for a trailing assign to finish its lowbit chain walk after
  // the last result.
  localparam int SETTLE_CYCLES = 40;
  // Generous bound on the whole run, well above the slowest legal run.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 8;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  cmd_item_t        cmd       = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_item_t        res;
  logic             cfg_we    = 1'b0;
  logic [POS_W-1:0] cfg_data  = '0;

  int fail_count;
  int results_outstanding;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int current_limit   = int'(LIMIT_RESET);

  always #6 clk = ~clk;

  fenwick_point_assign_range_sum_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  range_sum_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (results_outstanding)
  );

  // The receiver stalls on a fresh random draw each cycle, with a chance of
  // recv_stall_pct percent. Stall changes at the falling edge so that the block always sees a settled value.
  always @(negedge clk) begin
    res_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog. A hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cmd_item_t assign_item(int at, logic signed [VAL_W-1:0] v);
    cmd_item_t item;
    item             = '0;
    item.mode        = MODE_ASSIGN;
    item.position    = POS_W'(at);
    item.new_value   = v;
    return item;
  endfunction

  function automatic cmd_item_t query_item(int lo, int hi);
    cmd_item_t item;
    item             = '0;
    item.mode        = MODE_QUERY;
    item.left_bound  = POS_W'(lo);
    item.right_bound = POS_W'(hi);
    return item;
  endfunction

  // Random item shaped around the current limit. Most assigns land on a valid
  // position and most queries have valid, ordered bounds; the rest hit
  // position zero, positions or bounds past the limit, swapped bounds, a zero
  // left bound or fully random fields. Fields that the mode does not use are left random.
  function automatic cmd_item_t random_item(int lim);
    cmd_item_t item;
    int pick;
    int a;
    int b;
    item.mode        = 1'($urandom_range(1));
    item.position    = POS_W'($urandom_range(POS_MAX));
    item.new_value   = $urandom;
    item.left_bound  = POS_W'($urandom_range(POS_MAX));
    item.right_bound = POS_W'($urandom_range(POS_MAX));
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: item.new_value = 32'sh7fffffff;
        1: item.new_value = 32'sh80000000;
        2: item.new_value = '0;
        default: item.new_value = -32'sd1;
      endcase
    end
    if (lim > 0) begin
      if (item.mode == MODE_ASSIGN) begin
        if (pick < 80) item.position = POS_W'($urandom_range(lim, 1));
        else if (pick < 88) item.position = '0;
        else if (pick < 96 && lim < POS_MAX)
          item.position = POS_W'($urandom_range(POS_MAX, lim + 1));
      end else begin
        a = $urandom_range(lim, 1);
        b = $urandom_range(lim, 1);
        if (pick < 75) begin
          item.left_bound  = POS_W'((a < b) ? a : b);
          item.right_bound = POS_W'((a < b) ? b : a);
        end else if (pick < 83) begin
          item.left_bound  = POS_W'((a < b) ? b : a);
          item.right_bound = POS_W'((a < b) ? a : b);
        end else if (pick < 89) begin
          item.left_bound  = '0;
          item.right_bound = POS_W'(b);
        end else if (pick < 95 && lim < POS_MAX) begin
          item.left_bound  = POS_W'(a);
          item.right_bound = POS_W'(b);
          if ($urandom_range(1)) item.left_bound = POS_W'($urandom_range(POS_MAX, lim + 1));
          else item.right_bound = POS_W'($urandom_range(POS_MAX, lim + 1));
        end
      end
    end
    return item;
  endfunction

  // Called at a falling edge. An optional run of idle cycles comes first;
  // valid stays high from one item to the next when there is no gap, and the
  // task returns at the falling edge after the item was taken.
  task automatic send_item(input cmd_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drops valid, waits for every query to be answered, then gives a trailing
  // assign time to finish its chain walk before anything else happens.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The limit is only changed with the block idle.
  task automatic set_limit(input int lim);
    wait_idle();
    cfg_we        <= 1'b1;
    cfg_data      <= POS_W'(lim);
    current_limit  = lim;
    @(negedge clk);
    cfg_we        <= 1'b0;
  endtask

  initial begin
    int phase_limit [PHASES];
    int item_count;
    phase_limit = '{POS_MAX, 700, 1, POS_MAX, 0, 15, POS_MAX, 0};
    phase_limit[PHASES-1] = $urandom_range(POS_MAX - 1, 2);

    // Synchronous reset first. The block then clears its memories;
    // the first item simply waits on cmd_stall until that is done.
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with the reset limit of 1023. An empty tree sums to
    // zero; the extreme values at both ends plus -1 at 512 sum to -2; position
    // zero is ignored; reassigning a position replaces its value; swapped
    // bounds give the negated sum of the positions strictly between them.
    send_item(query_item(1, POS_MAX));
    send_item(assign_item(1, 32'sh7fffffff));
    send_item(assign_item(POS_MAX, 32'sh80000000));
    send_item(assign_item(512, -32'sd1));
    send_item(assign_item(0, 32'sd5));
    send_item(query_item(1, POS_MAX));
    send_item(assign_item(1, 32'sh80000000));
    send_item(query_item(1, 1));
    send_item(query_item(POS_MAX, POS_MAX));
    send_item(query_item(0, 5));
    send_item(query_item(600, 400));
    send_item(query_item(5, 5));
    send_item(query_item(1, POS_MAX));

    // With a zero limit every assign is dropped and every query is flagged.
    set_limit(0);
    send_item(assign_item(3, 32'sd9));
    send_item(query_item(1, 1));
    send_item(query_item(0, 0));

    // A limit in the middle: positions past it are ignored or flagged, and
    // contents written earlier are still there.
    set_limit(100);
    send_item(assign_item(101, 32'sd7));
    send_item(assign_item(100, 32'sd7));
    send_item(query_item(1, 101));
    send_item(query_item(100, 100));
    send_item(query_item(1, 100));

    // Back to the full range; the earlier write at 1023 is still counted.
    set_limit(POS_MAX);
    send_item(query_item(1, POS_MAX));

    // Random phases. Each one sets a new limit and an idling profile: none,
    // a sender that is mostly idle, a receiver that mostly stalls, and both.
    for (int p = 0; p < PHASES; p++) begin
      set_limit(phase_limit[p]);
      case (p % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 64;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 64;
        end
        default: begin
          send_idle_pct  <= 34;
          recv_stall_pct <= 34;
        end
      endcase
      @(negedge clk);
      // A zero limit makes the block ignore or flag everything, so that
      // phase is kept short.
      item_count = (phase_limit[p] == 0) ? 30 : 220;
      for (int i = 0; i < item_count; i++) begin
        send_item(random_item(current_limit));
      end
    end

    // Drain and give the verdict.
    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
